// ----- src/mts_pkg.sv -----
// Shared types and constants for the melody tone sequencer.
`default_nettype none

package mts_pkg;

  // Song table byte markers
  localparam logic [7:0] MARK_END  = 8'h00;
  localparam logic [7:0] MARK_REST = 8'hFF;

  // Configuration register indexes
  localparam logic [2:0] CFG_PLAY_ENABLE   = 3'd0;
  localparam logic [2:0] CFG_TONE_SCALE    = 3'd1;
  localparam logic [2:0] CFG_BEAT_PERIOD   = 3'd2;
  localparam logic [2:0] CFG_MS_PERIOD     = 3'd3;
  localparam logic [2:0] CFG_REST_PAUSE_MS = 3'd4;
  localparam logic [2:0] CFG_END_PAUSE_MS  = 3'd5;

  // Input beat kind carried in tuser
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Table write request toward the song memory
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } tbl_wr_t;

endpackage

`default_nettype wire

// ----- src/melody_tone_sequencer_unit.sv -----
// Top level: song table player producing one status beat per input beat.
// The status beat for an input beat is registered in the output register or skid entry.
// One input beat per cycle unless stalled; the table is read ahead at the next index.
// A two-entry output stage (register plus skid) absorbs one beat while out_tready is low;
// in_tready drops once the skid entry is full and returns when the output register drains.
// Reset: rst_n synchronous, active low; clears control state and loads register defaults.
// The song table is not cleared; entries are undefined until written.
`default_nettype none

module melody_tone_sequencer_unit
  import mts_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] entry_addr, [15:8] entry_data
  input  wire logic [0:0]  in_tuser,   // [0] action
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [0] pin_level, [8:1] song_index, [10:9] play_phase
  // Configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  typedef enum logic [1:0] {
    PH_FETCH = 2'd0,
    PH_TONE  = 2'd1,
    PH_REST  = 2'd2,
    PH_END   = 2'd3
  } phase_t;

  // Configuration registers
  logic        play_enable_r;
  logic [7:0]  tone_scale_r;
  logic [15:0] beat_period_r, ms_period_r, rest_pause_r, end_pause_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_enable_r <= 1'b0;
      tone_scale_r  <= 8'd3;
      beat_period_r <= 16'd10000;
      ms_period_r   <= 16'd200;
      rest_pause_r  <= 16'd100;
      end_pause_r   <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PLAY_ENABLE:   play_enable_r <= cfg_data[0];
        CFG_TONE_SCALE:    tone_scale_r  <= cfg_data[7:0];
        CFG_BEAT_PERIOD:   beat_period_r <= cfg_data;
        CFG_MS_PERIOD:     ms_period_r   <= cfg_data;
        CFG_REST_PAUSE_MS: rest_pause_r  <= cfg_data;
        CFG_END_PAUSE_MS:  end_pause_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake
  logic in_fire, is_tick;
  logic out_valid_r, skid_valid_r;
  logic [15:0] out_data_r, skid_data_r;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign is_tick   = in_fire && (in_tuser[0] == ACT_TICK);

  // Player state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  index_r, index_nxt;
  logic        pin_r, pin_nxt;
  logic [7:0]  tone_r, tone_nxt;
  logic [15:0] half_r, half_nxt;
  logic [7:0]  beat_cnt_r, beat_cnt_nxt;
  logic [15:0] beat_div_r, beat_div_nxt;
  logic [15:0] ms_div_r, ms_div_nxt;
  logic [15:0] pause_r, pause_nxt;

  // Song table
  tbl_wr_t    tbl_wr;
  logic [7:0] rd_a, rd_b;

  assign tbl_wr.en   = in_fire && (in_tuser[0] == ACT_WRITE);
  assign tbl_wr.addr = in_tdata[7:0];
  assign tbl_wr.data = in_tdata[15:8];

  // Read ahead at the index that holds after this edge
  mts_table_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk       (clk),
    .wr        (tbl_wr),
    .rd_idx_a  (index_nxt),
    .rd_idx_b  (index_nxt + 8'd1),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // Half-period load: scale * tone - 1, tone taken from the table on fetch
  logic [7:0]  mul_op;
  logic [15:0] product, half_load;
  assign mul_op    = (phase_r == PH_FETCH) ? rd_a : tone_r;
  assign product   = {8'd0, tone_scale_r} * {8'd0, mul_op};
  assign half_load = product - 16'd1;

  logic [16:0] beat_sum, ms_sum;
  logic [15:0] half_dec, pause_dec, pause_lit;
  logic [7:0]  beat_dec;
  assign beat_sum  = {1'b0, beat_div_r} + 17'd1;
  assign ms_sum    = {1'b0, ms_div_r} + 17'd1;
  assign half_dec  = (half_r != 16'd0) ? half_r - 16'd1 : 16'd0;
  assign pause_dec = (pause_r != 16'd0) ? pause_r - 16'd1 : 16'd0;
  assign pause_lit = (rd_a == MARK_END) ? end_pause_r - 16'd1 : rest_pause_r - 16'd1;

  // One base tick of the player
  always_comb begin
    phase_nxt    = phase_r;
    index_nxt    = index_r;
    pin_nxt      = pin_r;
    tone_nxt     = tone_r;
    half_nxt     = half_r;
    beat_cnt_nxt = beat_cnt_r;
    beat_div_nxt = beat_div_r;
    ms_div_nxt   = ms_div_r;
    pause_nxt    = pause_r;
    beat_dec     = beat_cnt_r;
    if (is_tick) begin
      if (!play_enable_r) begin
        index_nxt    = 8'd0;
        phase_nxt    = PH_FETCH;
        half_nxt     = 16'd0;
        beat_div_nxt = 16'd0;
        ms_div_nxt   = 16'd0;
        pause_nxt    = 16'd0;
      end else begin
        case (phase_r)
          PH_FETCH: begin
            if (rd_a == MARK_END || rd_a == MARK_REST) begin
              index_nxt  = (rd_a == MARK_END) ? 8'd0 : index_r + 8'd1;
              pause_nxt  = pause_lit;
              ms_div_nxt = 16'd0;
              if (pause_lit == 16'd0)
                phase_nxt = PH_FETCH;
              else
                phase_nxt = (rd_a == MARK_END) ? PH_END : PH_REST;
            end else begin
              tone_nxt     = rd_a;
              beat_cnt_nxt = rd_b;
              index_nxt    = index_r + 8'd2;
              beat_div_nxt = 16'd0;
              if (rd_b != 8'd0) begin
                pin_nxt   = !pin_r;
                half_nxt  = half_load;
                phase_nxt = PH_TONE;
              end
            end
          end
          PH_TONE: begin
            if (beat_sum >= {1'b0, beat_period_r}) begin
              beat_div_nxt = 16'd0;
              if (beat_cnt_r != 8'd0)
                beat_dec = beat_cnt_r - 8'd1;
            end else begin
              beat_div_nxt = beat_sum[15:0];
            end
            beat_cnt_nxt = beat_dec;
            half_nxt     = half_dec;
            if (half_dec == 16'd0) begin
              if (beat_dec == 8'd0) begin
                phase_nxt = PH_FETCH;
              end else begin
                pin_nxt  = !pin_r;
                half_nxt = half_load;
              end
            end
          end
          default: begin
            // Rest or end pause
            if (ms_sum >= {1'b0, ms_period_r}) begin
              ms_div_nxt = 16'd0;
              pause_nxt  = pause_dec;
              if (pause_dec == 16'd0)
                phase_nxt = PH_FETCH;
            end else begin
              ms_div_nxt = ms_sum[15:0];
            end
          end
        endcase
      end
    end
  end

  logic [15:0] result;
  assign result = {5'd0, phase_nxt, index_nxt, pin_nxt};

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FETCH;
      index_r      <= 8'd0;
      pin_r        <= 1'b0;
      tone_r       <= 8'd0;
      half_r       <= 16'd0;
      beat_cnt_r   <= 8'd0;
      beat_div_r   <= 16'd0;
      ms_div_r     <= 16'd0;
      pause_r      <= 16'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      index_r    <= index_nxt;
      pin_r      <= pin_nxt;
      tone_r     <= tone_nxt;
      half_r     <= half_nxt;
      beat_cnt_r <= beat_cnt_nxt;
      beat_div_r <= beat_div_nxt;
      ms_div_r   <= ms_div_nxt;
      pause_r    <= pause_nxt;
      // Output register with skid entry
      if (!out_valid_r || out_tready) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end else if (in_fire) begin
      skid_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_disabled_tick: assert property (@(posedge clk) disable iff (!rst_n)
    is_tick && !play_enable_r |=> (index_r == 8'd0) && (phase_r == PH_FETCH))
    else $error("tick while disabled did not rewind the player");

  a_write_no_state: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr.en |=> $stable(index_r) && $stable(pin_r) && $stable(phase_r))
    else $error("table write changed player state");

  a_pin_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !is_tick |=> $stable(pin_r))
    else $error("pin changed without a tick");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");
`endif

endmodule

`default_nettype wire

// ----- src/mts_table_mem.sv -----
// Song table memory: two synchronous copies, one read port each, with write bypass.
`default_nettype none

module mts_table_mem
  import mts_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  wire logic       clk,
  input  wire tbl_wr_t    wr,
  input  wire logic [7:0] rd_idx_a,
  input  wire logic [7:0] rd_idx_b,
  output logic [7:0]      rd_data_a,
  output logic [7:0]      rd_data_b
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Byte index folded onto the table depth (constant lookup)
  logic [AW-1:0] mod_lut [256];
  for (genvar g = 0; g < 256; g++) begin : g_lut
    assign mod_lut[g] = AW'(g % DEPTH);
  end

  logic [AW-1:0] wa, ra, rb;
  assign wa = mod_lut[wr.addr];
  assign ra = mod_lut[rd_idx_a];
  assign rb = mod_lut[rd_idx_b];

  logic [7:0] mem_a [DEPTH];
  logic [7:0] mem_b [DEPTH];
  logic [7:0] rd_a_r, rd_b_r;

  // Write both copies; a read of the entry being written returns the new byte
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_a[wa] <= wr.data;
      mem_b[wa] <= wr.data;
    end
    rd_a_r <= (wr.en && (wa == ra)) ? wr.data : mem_a[ra];
    rd_b_r <= (wr.en && (wa == rb)) ? wr.data : mem_b[rb];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

`default_nettype wire
